// File: design/dll_pkg.sv
// shared types and codes for the doubly linked list engine
package dll_pkg;

  localparam int NODE_W = 8;

  localparam logic [2:0] OP_INSERT_BEFORE = 3'd0;
  localparam logic [2:0] OP_INSERT_AFTER  = 3'd1;
  localparam logic [2:0] OP_INSERT_FIRST  = 3'd2;
  localparam logic [2:0] OP_INSERT_LAST   = 3'd3;
  localparam logic [2:0] OP_DETACH        = 3'd4;

  typedef struct packed {
    logic [2:0]        operation;
    logic [NODE_W-1:0] anchor_node;
    logic [NODE_W-1:0] target_node;
  } dll_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] head_node;
    logic [NODE_W-1:0] tail_node;
    logic [NODE_W-1:0] node_count;
    logic              bad_request;
  } dll_rsp_t;

endpackage

// File: design/dll_ram.sv
// generic single-write, single-read ram with registered read
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/doubly_linked_list_engine.sv
// doubly linked list engine: top level with link memories and request sequencer
//
// Keeps one doubly linked list over node indices 1 to NODE_SLOTS-1 (index 0 is
// the null link) in two link memories, previous and next, plus head, tail and a
// saturating count. Each accepted word inserts a node before or after an anchor,
// as first or last, or detaches it, and returns one word with head, tail and
// count after the request. A request that names node 0 or a node beyond the
// table where a node is needed, or an unknown operation, changes nothing and
// returns bad_request set. After acceptance a valid request steps through S_RD,
// which reads both link memories, and the write states S_W1 and S_W2, since
// each memory has a single write port and a request writes up to two entries
// in each; its result is loaded in S_W2, or in S_RESP while the output register
// is full. A refused request goes from acceptance to S_RESP, where its result is
// loaded. The input is stalled while a request is in progress and while a
// result waits for a full output register; a finished result waits in the
// output register while the next word is accepted. The link memories need no
// clearing after reset.
module doubly_linked_list_engine
  import dll_pkg::*;
#(
  parameter int NODE_SLOTS = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dll_req_t in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output dll_rsp_t out_word
);

  localparam int DEPTH = (NODE_SLOTS > 256) ? 256 : NODE_SLOTS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_W1, S_W2, S_RESP} state_t;
  typedef enum logic [1:0] {K_BEFORE, K_AFTER, K_SOLO, K_DETACH} kind_t;

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [NODE_W-1:0] anc_r, anc_nxt;
  logic [NODE_W-1:0] tgt_r, tgt_nxt;
  logic              bad_r, bad_nxt;
  logic [NODE_W-1:0] head_r, head_nxt;
  logic [NODE_W-1:0] tail_r, tail_nxt;
  logic [NODE_W-1:0] count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  dll_rsp_t          out_word_r, out_word_nxt;

  logic              prev_we, next_we, rd_en;
  logic [AW-1:0]     prev_wa, next_wa, rd_addr;
  logic [NODE_W-1:0] prev_wd, next_wd;
  logic [NODE_W-1:0] p_link, n_link;
  logic              out_free, in_fire, req_bad;

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return (n != '0) && ({{(32-NODE_W){1'b0}}, n} < 32'(NODE_SLOTS));
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] n);
    return n[AW-1:0];
  endfunction

  dll_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_prev_ram (
    .clk     (clk),
    .wr_en   (prev_we),
    .wr_addr (prev_wa),
    .wr_data (prev_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (p_link)
  );

  dll_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_next_ram (
    .clk     (clk),
    .wr_en   (next_we),
    .wr_addr (next_wa),
    .wr_data (next_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (n_link)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign rd_en     = (state_r == S_RD);
  assign rd_addr   = (kind_r == K_DETACH) ? to_addr(tgt_r) : to_addr(anc_r);

  assign req_bad = (in_word.operation > OP_DETACH) || !node_ok(in_word.target_node) ||
                   ((in_word.operation <= OP_INSERT_AFTER) && !node_ok(in_word.anchor_node));

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    anc_nxt       = anc_r;
    tgt_nxt       = tgt_r;
    bad_nxt       = bad_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    prev_we       = 1'b0;
    next_we       = 1'b0;
    prev_wa       = to_addr(tgt_r);
    next_wa       = to_addr(tgt_r);
    prev_wd       = '0;
    next_wd       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tgt_nxt = in_word.target_node;
          anc_nxt = in_word.anchor_node;
          bad_nxt = req_bad;
          case (in_word.operation)
            OP_INSERT_BEFORE: kind_nxt = K_BEFORE;
            OP_INSERT_AFTER:  kind_nxt = K_AFTER;
            OP_INSERT_FIRST: begin
              if (head_r != '0) begin
                kind_nxt = K_BEFORE;
                anc_nxt  = head_r;
              end else begin
                kind_nxt = K_SOLO;
              end
            end
            OP_INSERT_LAST: begin
              if (tail_r != '0) begin
                kind_nxt = K_AFTER;
                anc_nxt  = tail_r;
              end else if (head_r != '0) begin
                kind_nxt = K_BEFORE;
                anc_nxt  = head_r;
              end else begin
                kind_nxt = K_SOLO;
              end
            end
            default: kind_nxt = K_DETACH;
          endcase
          state_nxt = req_bad ? S_RESP : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_W1;
      end
      S_W1: begin
        case (kind_r)
          K_BEFORE: begin
            prev_we = 1'b1;
            prev_wd = p_link;
            next_we = 1'b1;
            next_wd = anc_r;
            if (p_link == '0) begin
              head_nxt = tgt_r;
            end
          end
          K_AFTER: begin
            prev_we = 1'b1;
            prev_wd = anc_r;
            next_we = 1'b1;
            next_wd = n_link;
            if (n_link == '0) begin
              tail_nxt = tgt_r;
            end
          end
          K_SOLO: begin
            prev_we  = 1'b1;
            next_we  = 1'b1;
            head_nxt = tgt_r;
            tail_nxt = tgt_r;
          end
          default: begin
            next_we = node_ok(p_link);
            next_wa = to_addr(p_link);
            next_wd = n_link;
            prev_we = node_ok(n_link);
            prev_wa = to_addr(n_link);
            prev_wd = p_link;
            if (p_link == '0) begin
              head_nxt = n_link;
            end
            if (n_link == '0) begin
              tail_nxt = p_link;
            end
          end
        endcase
        if (kind_r == K_DETACH) begin
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end else if (count_r != '1) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_W2;
      end
      S_W2: begin
        case (kind_r)
          K_BEFORE: begin
            prev_we = 1'b1;
            prev_wa = to_addr(anc_r);
            prev_wd = tgt_r;
            next_we = node_ok(p_link);
            next_wa = to_addr(p_link);
            next_wd = tgt_r;
          end
          K_AFTER: begin
            prev_we = node_ok(n_link);
            prev_wa = to_addr(n_link);
            prev_wd = tgt_r;
            next_we = 1'b1;
            next_wa = to_addr(anc_r);
            next_wd = tgt_r;
          end
          K_SOLO: begin
            prev_we = 1'b0;
          end
          default: begin
            prev_we = 1'b1;
            next_we = 1'b1;
          end
        endcase
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{head_node: head_r, tail_node: tail_r,
                            node_count: count_r, bad_request: 1'b0};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{head_node: head_r, tail_node: tail_r,
                            node_count: count_r, bad_request: bad_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_word_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_word_r  <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    anc_r      <= anc_nxt;
    tgt_r      <= tgt_nxt;
    bad_r      <= bad_nxt;
  end

  // count moves by at most one per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r) || count_r == $past(count_r) + 8'd1 ||
              count_r == $past(count_r) - 8'd1))
    else $error("count jumped");

  // a refused request leaves the list untouched
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && bad_r) |-> ($stable(head_r) && $stable(tail_r) && $stable(count_r)))
    else $error("refused request changed list state");

  // link memories are written only in the write cycles
  assert property (@(posedge clk) disable iff (!rst_n)
    (prev_we || next_we) |-> (state_r == S_W1 || state_r == S_W2))
    else $error("link write outside write cycles");

  // a result is loaded only when the output register is free
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(out_word_r) && out_valid_r))
    else $error("pending result overwritten");

endmodule

// File: bench/doubly_linked_list_engine_test.sv
// self-checking bench for the doubly linked list engine: directed table, then random list traffic
`timescale 1ns / 100ps

module doubly_linked_list_engine_test;
  import dll_pkg::*;

  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam logic [7:0] NULL_NODE = 8'd0;
  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam int FULL_LIST = 255;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    dll_req_t req;
    bit       typed;
    dll_rsp_t rsp;
  } step_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  dll_req_t in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  dll_rsp_t out_word;

  doubly_linked_list_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted list state
  logic [7:0] lnk_prev[256];
  logic [7:0] lnk_next[256];
  logic [7:0] lst_head = '0;
  logic [7:0] lst_tail = '0;
  logic [7:0] lst_count = '0;
  bit         node_written[256];

  // stimulus view of list membership
  logic [7:0] member_list[256];
  int         member_pos[256];
  bit         member_flag[256];
  int         member_total = 0;

  dll_rsp_t   list_status_q[$];
  step_t      plan[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         words_sent = 0;
  int         refused_sent = 0;
  int         deepest = 0;
  int         holds_done = 0;
  int         burst_left = 0;
  int         cycle_count = 0;

  task automatic bump_count();
    if (lst_count != COUNT_MAX) lst_count++;
  endtask

  task automatic link_before(input logic [7:0] a, input logic [7:0] t);
    logic [7:0] p;
    p = lnk_prev[a];
    lnk_prev[t] = p;
    lnk_next[t] = a;
    if (p == NULL_NODE) lst_head = t;
    else lnk_next[p] = t;
    lnk_prev[a] = t;
    bump_count();
  endtask

  task automatic link_after(input logic [7:0] a, input logic [7:0] t);
    logic [7:0] n;
    n = lnk_next[a];
    lnk_prev[t] = a;
    lnk_next[t] = n;
    if (n == NULL_NODE) lst_tail = t;
    else lnk_prev[n] = t;
    lnk_next[a] = t;
    bump_count();
  endtask

  task automatic link_first(input logic [7:0] t);
    if (lst_head == NULL_NODE) begin
      lst_head = t;
      lst_tail = t;
      lnk_prev[t] = NULL_NODE;
      lnk_next[t] = NULL_NODE;
      bump_count();
    end else begin
      link_before(lst_head, t);
    end
  endtask

  task automatic apply_list_request(input dll_req_t r, output dll_rsp_t s);
    logic [7:0] a, t, p, n, last;
    logic       refused;
    int         pos;
    a = r.anchor_node;
    t = r.target_node;
    refused = (r.operation > OP_DETACH) || (t == NULL_NODE) ||
              ((r.operation == OP_INSERT_BEFORE || r.operation == OP_INSERT_AFTER) &&
               a == NULL_NODE);
    if (!refused) begin
      case (r.operation)
        OP_INSERT_BEFORE: link_before(a, t);
        OP_INSERT_AFTER: link_after(a, t);
        OP_INSERT_FIRST: link_first(t);
        OP_INSERT_LAST: begin
          if (lst_tail == NULL_NODE) link_first(t);
          else link_after(lst_tail, t);
        end
        default: begin
          p = lnk_prev[t];
          n = lnk_next[t];
          if (p == NULL_NODE) lst_head = n;
          else lnk_next[p] = n;
          if (n == NULL_NODE) lst_tail = p;
          else lnk_prev[n] = p;
          lnk_prev[t] = NULL_NODE;
          lnk_next[t] = NULL_NODE;
          if (lst_count != 8'd0) lst_count--;
        end
      endcase
      node_written[t] = 1'b1;
      if (r.operation == OP_DETACH) begin
        if (member_flag[t]) begin
          pos = member_pos[t];
          member_total--;
          last = member_list[member_total];
          member_list[pos] = last;
          member_pos[last] = pos;
          member_flag[t] = 1'b0;
        end
      end else if (!member_flag[t]) begin
        member_list[member_total] = t;
        member_pos[t] = member_total;
        member_total++;
        member_flag[t] = 1'b1;
      end
    end
    if (int'(lst_count) > deepest) deepest = int'(lst_count);
    s.head_node = lst_head;
    s.tail_node = lst_tail;
    s.node_count = lst_count;
    s.bad_request = refused;
  endtask

  task automatic add_row(input logic [2:0] op, input logic [7:0] anc, input logic [7:0] tgt,
                         input bit typed, input logic [7:0] h, input logic [7:0] tl,
                         input logic [7:0] c, input logic b);
    step_t st;
    st.req.operation = op;
    st.req.anchor_node = anc;
    st.req.target_node = tgt;
    st.typed = typed;
    st.rsp.head_node = h;
    st.rsp.tail_node = tl;
    st.rsp.node_count = c;
    st.rsp.bad_request = b;
    plan.push_back(st);
  endtask

  task automatic send_word(input dll_req_t r, input bit typed, input dll_rsp_t typed_rsp);
    dll_rsp_t s;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_request(r, s);
    if (s.bad_request) refused_sent++;
    words_sent++;
    list_status_q.push_back(typed ? typed_rsp : s);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (list_status_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_member();
    return member_list[$urandom_range(member_total - 1)];
  endfunction

  task automatic pick_request(input int ins_pct, input int mis_pct, output dll_req_t r);
    int  roll, tries;
    bit  grow, misuse, done;
    logic [7:0] t;
    r.operation = OP_INSERT_FIRST;
    r.anchor_node = 8'($urandom_range(255));
    r.target_node = NULL_NODE;
    done = 1'b0;
    roll = $urandom_range(99);
    if (roll < 6) begin
      done = 1'b1;
      if (roll < 2) begin
        r.operation = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        r.target_node = 8'($urandom_range(255));
      end else if (roll < 4) begin
        r.operation = 3'($urandom_range(OP_INSERT_BEFORE, OP_DETACH));
      end else begin
        r.operation = ($urandom_range(1) == 0) ? OP_INSERT_BEFORE : OP_INSERT_AFTER;
        r.anchor_node = NULL_NODE;
        r.target_node = 8'($urandom_range(1, 255));
      end
    end
    grow = ($urandom_range(99) < ins_pct);
    misuse = ($urandom_range(99) < mis_pct);
    if (!done && misuse) begin
      if (grow && member_total > 0) begin
        r.operation = 3'($urandom_range(OP_INSERT_BEFORE, OP_INSERT_LAST));
        r.target_node = any_member();
        done = 1'b1;
      end else if (!grow) begin
        for (tries = 0; tries < 40 && !done; tries++) begin
          t = 8'($urandom_range(1, 255));
          if (node_written[t] && !member_flag[t]) begin
            r.operation = OP_DETACH;
            r.target_node = t;
            done = 1'b1;
          end
        end
      end
    end
    if (!done) begin
      if (member_total == 0) grow = 1'b1;
      if (member_total == FULL_LIST) grow = 1'b0;
      if (grow) begin
        do t = 8'($urandom_range(1, 255)); while (member_flag[t]);
        r.operation = 3'($urandom_range(OP_INSERT_BEFORE, OP_INSERT_LAST));
        r.target_node = t;
      end else begin
        r.operation = OP_DETACH;
        r.target_node = any_member();
      end
    end
    if (r.target_node != NULL_NODE &&
        (r.operation == OP_INSERT_BEFORE || r.operation == OP_INSERT_AFTER) &&
        r.anchor_node != NULL_NODE) begin
      if (member_total == 0)
        r.operation = (r.operation == OP_INSERT_BEFORE) ? OP_INSERT_FIRST : OP_INSERT_LAST;
      else
        r.anchor_node = any_member();
    end
  endtask

  task automatic run_phase(input int ins_pct, input int mis_pct, input int cap,
                           input int goal);
    dll_req_t r;
    int k;
    for (k = 0; k < cap && member_total != goal; k++) begin
      pick_request(ins_pct, mis_pct, r);
      send_word(r, 1'b0, '0);
    end
    settle();
  endtask

  task automatic note_mismatch(input dll_rsp_t want, input dll_rsp_t got, input bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("result word with nothing pending: head %0d tail %0d count %0d bad %0d",
                 got.head_node, got.tail_node, got.node_count, got.bad_request);
      else
        $display({"mismatch at result %0d: want head %0d tail %0d count %0d bad %0d,",
                  " got %0d %0d %0d %0d"},
                 results_seen, want.head_node, want.tail_node, want.node_count,
                 want.bad_request, got.head_node, got.tail_node, got.node_count,
                 got.bad_request);
    end
  endtask

  always @(posedge clk) begin
    dll_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (list_status_q.size() == 0) begin
        note_mismatch('0, out_word, 1'b1);
      end else begin
        want = list_status_q.pop_front();
        if (out_word.head_node !== want.head_node || out_word.tail_node !== want.tail_node ||
            out_word.node_count !== want.node_count ||
            out_word.bad_request !== want.bad_request)
          note_mismatch(want, out_word, 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count,
               list_status_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: stretches of free flow, light and heavy stalls, two long hold-offs
  initial begin
    int mode, span;
    @(posedge clk);
    forever begin
      if (holds_done < 2 && results_seen >= ((holds_done == 0) ? 150 : 900)) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(2);
        span = $urandom_range(4, 40);
        repeat (span) begin
          if (mode == 0) out_stall <= 1'b0;
          else if (mode == 1) out_stall <= ($urandom_range(3) == 0);
          else out_stall <= ($urandom_range(3) != 0);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    add_row(OP_INSERT_FIRST, 8'd0, NULL_NODE, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
    add_row(OP_RSVD_LO, 8'd1, 8'd1, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
    add_row(OP_INSERT_FIRST, 8'd0, 8'd1, 1'b1, 8'd1, 8'd1, 8'd1, 1'b0);
    add_row(OP_INSERT_BEFORE, NULL_NODE, 8'd2, 1'b1, 8'd1, 8'd1, 8'd1, 1'b1);
    add_row(OP_INSERT_AFTER, NULL_NODE, 8'd2, 1'b1, 8'd1, 8'd1, 8'd1, 1'b1);
    add_row(OP_INSERT_LAST, 8'd0, 8'd255, 1'b1, 8'd1, 8'd255, 8'd2, 1'b0);
    add_row(OP_INSERT_BEFORE, 8'd1, 8'd128, 1'b1, 8'd128, 8'd255, 8'd3, 1'b0);
    add_row(OP_INSERT_AFTER, 8'd255, 8'd254, 1'b1, 8'd128, 8'd254, 8'd4, 1'b0);
    add_row(OP_INSERT_AFTER, 8'd1, 8'd2, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_INSERT_BEFORE, 8'd255, 8'd3, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd255, NULL_NODE, 1'b1, 8'd128, 8'd254, 8'd6, 1'b1);
    add_row(OP_DETACH, 8'd0, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd0, 8'd254, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd0, 8'd2, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_RSVD_HI, 8'd255, 8'd255, 1'b1, 8'd1, 8'd255, 8'd3, 1'b1);
    add_row(OP_DETACH, 8'd0, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd0, 8'd3, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd0, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd0, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_INSERT_LAST, 8'd0, 8'd7, 1'b1, 8'd7, 8'd7, 8'd1, 1'b0);
    add_row(OP_INSERT_FIRST, 8'd0, 8'd9, 1'b1, 8'd9, 8'd7, 8'd2, 1'b0);
    add_row(OP_INSERT_LAST, 8'd0, 8'd9, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd0, 8'd9, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd0, 8'd7, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_row(OP_DETACH, 8'd0, 8'd9, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_word(plan[i].req, plan[i].typed, plan[i].rsp);
    settle();

    run_phase(55, 0, 600, -1);
    run_phase(90, 0, 1000, FULL_LIST);
    run_phase(100, 100, 12, -1);
    run_phase(10, 5, 1000, 0);
    run_phase(50, 10, 120, -1);

    repeat (16) @(posedge clk);

    $display("sent %0d request words (%0d refused), checked %0d result words",
             words_sent, refused_sent, results_seen);
    $display("list grew to %0d nodes, receiver held off %0d times", deepest, holds_done);
    if (mismatches == 0 && list_status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, list_status_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: doubly_linked_list_engine.f
design/dll_pkg.sv
design/dll_ram.sv
design/doubly_linked_list_engine.sv
bench/doubly_linked_list_engine_test.sv
